/* design/pipcp_pkg.sv */
// Shared constants and types for the convex polygon membership block.
`timescale 1ns / 1ps

package pipcp_pkg;

    // Width of the coordinate fields on the input channel.
    localparam int POINT_W = 32;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_VERTICES = 1024;
    localparam int DEF_COORD_WIDTH  = 32;

    // Width of one multiplier digit in the shared multiply-accumulate unit.
    localparam int DIG_W = 16;

    typedef logic [1:0] opcode_t;
    typedef logic [1:0] position_t;

    localparam opcode_t OP_CLEAR  = 2'd0;
    localparam opcode_t OP_APPEND = 2'd1;
    localparam opcode_t OP_QUERY  = 2'd2;

    localparam position_t POS_INSIDE   = 2'd0;
    localparam position_t POS_BOUNDARY = 2'd1;
    localparam position_t POS_OUTSIDE  = 2'd2;
    localparam position_t POS_INVALID  = 2'd3;

endpackage

/* design/point_in_convex_polygon.sv */
// Convex polygon membership unit: vertex table, sequencer and shared multiply-accumulate unit.
`timescale 1ns / 1ps

// The block holds a convex polygon as a table of vertices and answers point queries. Each input
// transaction carries an opcode: clear empties the table and the sticky overflow flag, append adds
// one vertex (dropped, with overflow set, when the table already holds MAX_VERTICES), and query
// returns one result transaction with the position of the point (inside, on the boundary, outside,
// or invalid when fewer than three vertices are stored) and the overflow flag. Vertices must be
// given counter-clockwise, starting at the lowest and then leftmost vertex, with no three collinear;
// otherwise the answer is well defined but has no geometric meaning. Clear and append leave the
// sequencer idle, so another transaction can follow at once. A query runs as a chain of exact
// cross and dot products through one multiply-accumulate unit that handles the multiplier operand
// in ceil((COORD_WIDTH+1)/16) digits; each product passes through a vertex memory read, operand
// set-up, multiply-accumulate over the digits of both terms, and a sign decision. s_ready stays
// low from the acceptance of a query until its result is in the output register. A finished
// result waits in the output register until it is taken; the sequencer returns to idle as soon
// as the result is in that register, and a result that is still waiting there holds the next
// one back.
module point_in_convex_polygon #(
    parameter int MAX_VERTICES = pipcp_pkg::DEF_MAX_VERTICES,
    parameter int COORD_WIDTH  = pipcp_pkg::DEF_COORD_WIDTH
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,

    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  pipcp_pkg::opcode_t                      s_opcode,
    input  logic signed [pipcp_pkg::POINT_W-1:0]    s_point_x,
    input  logic signed [pipcp_pkg::POINT_W-1:0]    s_point_y,

    output logic                                    m_valid,
    input  logic                                    m_ready,
    output pipcp_pkg::position_t                    m_position,
    output logic                                    m_overflow
);

    import pipcp_pkg::*;

    // Coordinate, difference and accumulator widths. Differences of two coordinates need one extra
    // bit; a sum of two such products needs twice that plus one.
    localparam int CW     = COORD_WIDTH;
    localparam int AW     = CW + 1;
    localparam int ND     = (AW + DIG_W - 1) / DIG_W;
    localparam int BW     = ND * DIG_W;
    localparam int PROD_W = AW + DIG_W + 1;
    localparam int ACC_W  = 2 * AW + 1;
    localparam int DIG_CW = (ND > 1) ? $clog2(ND) : 1;
    localparam int IDX_W  = $clog2(MAX_VERTICES);
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_FETCH  = 3'd1;
    localparam logic [2:0] ST_LOAD   = 3'd2;
    localparam logic [2:0] ST_MAC    = 3'd3;
    localparam logic [2:0] ST_EVAL   = 3'd4;
    localparam logic [2:0] ST_SEARCH = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    // What the current vertex fetch is for.
    localparam logic [2:0] J_FIRST  = 3'd0;  // edge from vertex zero to vertex one
    localparam logic [2:0] J_CLOSE  = 3'd1;  // edge from the last vertex back to vertex zero
    localparam logic [2:0] J_DOT    = 3'd2;  // on-segment test along one of those edges
    localparam logic [2:0] J_SEARCH = 3'd3;  // one step of the wedge search
    localparam logic [2:0] J_PREV   = 3'd4;  // fetch the inner end of the wedge's outer edge
    localparam logic [2:0] J_FINAL  = 3'd5;  // side of the wedge's outer edge

    localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_VERTICES);
    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_TWO   = CNT_W'(2);
    localparam logic [CNT_W-1:0] CNT_THREE = CNT_W'(3);
    localparam logic [DIG_CW-1:0] DIG_LAST = DIG_CW'(ND - 1);

    // ------------------------------------------------------------------------------------------
    // Input coordinates. A narrower coordinate keeps the low bits as a two's complement value; a
    // wider one is zero-extended, so it is never negative.
    // ------------------------------------------------------------------------------------------
    logic signed [CW-1:0] in_x;
    logic signed [CW-1:0] in_y;

    generate
        if (COORD_WIDTH > POINT_W) begin : g_wide
            assign in_x = {{(COORD_WIDTH - POINT_W){1'b0}}, s_point_x};
            assign in_y = {{(COORD_WIDTH - POINT_W){1'b0}}, s_point_y};
        end else begin : g_narrow
            assign in_x = s_point_x[CW-1:0];
            assign in_y = s_point_y[CW-1:0];
        end
    endgenerate

    // ------------------------------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------------------------------
    logic [2:0]              state_reg, state_next;
    logic [2:0]              job_reg, job_next;
    logic [CNT_W-1:0]        vcount_reg, vcount_next;
    logic                    ovf_reg, ovf_next;
    logic                    m_valid_reg, m_valid_next;
    logic                    mac_issue_reg, mac_issue_next;
    logic                    prod_vld_reg, prod_vld_next;

    logic signed [CW-1:0]    px_reg, px_next;
    logic signed [CW-1:0]    py_reg, py_next;
    logic signed [CW-1:0]    ox_reg, ox_next;
    logic signed [CW-1:0]    oy_reg, oy_next;
    logic signed [CW-1:0]    qx_reg, qx_next;
    logic signed [CW-1:0]    qy_reg, qy_next;
    logic [CNT_W-1:0]        fetch_reg, fetch_next;
    logic [CNT_W-1:0]        lo_reg, lo_next;
    logic [CNT_W-1:0]        hi_reg, hi_next;
    logic [CNT_W-1:0]        pos_reg, pos_next;
    logic                    first_zero_reg, first_zero_next;
    position_t               res_reg, res_next;
    position_t               m_position_reg, m_position_next;
    logic                    m_overflow_reg, m_overflow_next;

    logic signed [AW-1:0]    a0_reg, a0_next;
    logic signed [AW-1:0]    b0_reg, b0_next;
    logic signed [AW-1:0]    a1_reg, a1_next;
    logic signed [AW-1:0]    b1_reg, b1_next;
    logic                    sub_reg, sub_next;
    logic                    term_reg, term_next;
    logic [DIG_CW-1:0]       dig_reg, dig_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [DIG_CW-1:0]       prod_dig_reg, prod_dig_next;
    logic                    prod_neg_reg, prod_neg_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;

    // Vertex table: x in the low half of a word, y in the high half.
    logic [2*CW-1:0]         vert_mem [MAX_VERTICES];
    logic [2*CW-1:0]         rd_data_reg;
    logic                    mem_we;

    // ------------------------------------------------------------------------------------------
    // Combinational helpers.
    // ------------------------------------------------------------------------------------------
    logic signed [CW-1:0]    wx;
    logic signed [CW-1:0]    wy;
    logic signed [CW-1:0]    m0, s0, m1, s1, m2, s2, m3, s3;
    logic signed [AW-1:0]    d0, d1, d2, d3;
    logic signed [AW-1:0]    mul_a;
    logic signed [AW-1:0]    mul_b;
    logic signed [BW-1:0]    mul_b_ext;
    logic [DIG_W-1:0]        digit;
    logic signed [DIG_W:0]   digit_ext;
    logic signed [ACC_W-1:0] acc_term;
    logic                    acc_neg;
    logic                    acc_zero;
    logic                    acc_pos;
    logic [CNT_W-1:0]        last_idx;
    logic [CNT_W:0]          mid_sum;

    assign wx = rd_data_reg[CW-1:0];
    assign wy = rd_data_reg[2*CW-1:CW];

    assign last_idx = vcount_reg - 1'b1;
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};

    // Operand set-up: four coordinate differences per product pair. For the edge and wedge tests
    // the pair is a cross product, for the on-segment test a dot product.
    always_comb begin
        m0 = px_reg; s0 = ox_reg;
        m1 = wy;     s1 = oy_reg;
        m2 = py_reg; s2 = oy_reg;
        m3 = wx;     s3 = ox_reg;
        case (job_reg)
            J_CLOSE: begin
                m0 = wx;     s0 = ox_reg;
                m1 = py_reg; s1 = oy_reg;
                m2 = wy;     s2 = oy_reg;
                m3 = px_reg; s3 = ox_reg;
            end
            J_DOT: begin
                m0 = ox_reg; s0 = px_reg;
                m1 = wx;     s1 = px_reg;
                m2 = oy_reg; s2 = py_reg;
                m3 = wy;     s3 = py_reg;
            end
            J_FINAL: begin
                m0 = wx;     s0 = qx_reg;
                m1 = py_reg; s1 = qy_reg;
                m2 = wy;     s2 = qy_reg;
                m3 = px_reg; s3 = qx_reg;
            end
            default: begin
            end
        endcase
    end

    assign d0 = {m0[CW-1], m0} - {s0[CW-1], s0};
    assign d1 = {m1[CW-1], m1} - {s1[CW-1], s1};
    assign d2 = {m2[CW-1], m2} - {s2[CW-1], s2};
    assign d3 = {m3[CW-1], m3} - {s3[CW-1], s3};

    // Multiplier: one signed operand against one digit of the other. Lower digits are unsigned,
    // the top digit carries the sign.
    assign mul_a     = term_reg ? a1_reg : a0_reg;
    assign mul_b     = term_reg ? b1_reg : b0_reg;
    assign mul_b_ext = BW'(mul_b);
    assign digit     = mul_b_ext[dig_reg*DIG_W +: DIG_W];
    assign digit_ext = {(dig_reg == DIG_LAST) & digit[DIG_W-1], digit};

    assign acc_term = ACC_W'(prod_reg) <<< (DIG_W * prod_dig_reg);
    assign acc_neg  = acc_reg[ACC_W-1];
    assign acc_zero = (acc_reg == '0);
    assign acc_pos  = !acc_neg && !acc_zero;

    // ------------------------------------------------------------------------------------------
    // Sequencer and datapath next-state logic.
    // ------------------------------------------------------------------------------------------
    always_comb begin
        state_next      = state_reg;
        job_next        = job_reg;
        vcount_next     = vcount_reg;
        ovf_next        = ovf_reg;
        m_valid_next    = m_valid_reg;
        mac_issue_next  = mac_issue_reg;
        prod_vld_next   = prod_vld_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        ox_next         = ox_reg;
        oy_next         = oy_reg;
        qx_next         = qx_reg;
        qy_next         = qy_reg;
        fetch_next      = fetch_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        pos_next        = pos_reg;
        first_zero_next = first_zero_reg;
        res_next        = res_reg;
        m_position_next = m_position_reg;
        m_overflow_next = m_overflow_reg;
        a0_next         = a0_reg;
        b0_next         = b0_reg;
        a1_next         = a1_reg;
        b1_next         = b1_reg;
        sub_next        = sub_reg;
        term_next       = term_reg;
        dig_next        = dig_reg;
        prod_next       = prod_reg;
        prod_dig_next   = prod_dig_reg;
        prod_neg_next   = prod_neg_reg;
        acc_next        = acc_reg;
        mem_we          = 1'b0;

        // The result leaves as soon as the consumer takes it.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_opcode)
                        OP_CLEAR: begin
                            vcount_next = '0;
                            ovf_next    = 1'b0;
                        end
                        OP_APPEND: begin
                            if (vcount_reg == CNT_MAX) begin
                                ovf_next = 1'b1;
                            end else begin
                                mem_we      = 1'b1;
                                vcount_next = vcount_reg + 1'b1;
                                // Vertex zero is used by every query, so keep a copy at hand.
                                if (vcount_reg == '0) begin
                                    ox_next = in_x;
                                    oy_next = in_y;
                                end
                            end
                        end
                        OP_QUERY: begin
                            px_next = in_x;
                            py_next = in_y;
                            if (vcount_reg < CNT_THREE) begin
                                res_next   = POS_INVALID;
                                state_next = ST_DONE;
                            end else begin
                                fetch_next = CNT_ONE;
                                job_next   = J_FIRST;
                                state_next = ST_FETCH;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_FETCH: begin
                // The vertex memory is read at the end of this cycle.
                state_next = ST_LOAD;
            end

            ST_LOAD: begin
                if (job_reg == J_PREV) begin
                    qx_next    = wx;
                    qy_next    = wy;
                    fetch_next = pos_reg;
                    job_next   = J_FINAL;
                    state_next = ST_FETCH;
                end else begin
                    a0_next        = d0;
                    b0_next        = d1;
                    a1_next        = d2;
                    b1_next        = d3;
                    sub_next       = (job_reg != J_DOT);
                    term_next      = 1'b0;
                    dig_next       = '0;
                    acc_next       = '0;
                    mac_issue_next = 1'b1;
                    prod_vld_next  = 1'b0;
                    state_next     = ST_MAC;
                end
            end

            ST_MAC: begin
                // Issue one digit product per cycle and accumulate the previous one.
                if (mac_issue_reg) begin
                    prod_next     = mul_a * digit_ext;
                    prod_dig_next = dig_reg;
                    prod_neg_next = term_reg & sub_reg;
                    prod_vld_next = 1'b1;
                    if (dig_reg == DIG_LAST) begin
                        dig_next = '0;
                        if (term_reg) begin
                            mac_issue_next = 1'b0;
                        end else begin
                            term_next = 1'b1;
                        end
                    end else begin
                        dig_next = dig_reg + 1'b1;
                    end
                end else begin
                    prod_vld_next = 1'b0;
                end
                if (prod_vld_reg) begin
                    acc_next = prod_neg_reg ? acc_reg - acc_term : acc_reg + acc_term;
                end
                if (!mac_issue_reg && prod_vld_reg) begin
                    state_next = ST_EVAL;
                end
            end

            ST_EVAL: begin
                case (job_reg)
                    J_FIRST: begin
                        if (acc_pos) begin
                            res_next   = POS_OUTSIDE;
                            state_next = ST_DONE;
                        end else begin
                            first_zero_next = acc_zero;
                            fetch_next      = last_idx;
                            job_next        = J_CLOSE;
                            state_next      = ST_FETCH;
                        end
                    end
                    J_CLOSE: begin
                        if (acc_pos) begin
                            res_next   = POS_OUTSIDE;
                            state_next = ST_DONE;
                        end else if (first_zero_reg) begin
                            // Point on the line of the first edge: is it between its ends?
                            fetch_next = CNT_ONE;
                            job_next   = J_DOT;
                            state_next = ST_FETCH;
                        end else if (acc_zero) begin
                            fetch_next = last_idx;
                            job_next   = J_DOT;
                            state_next = ST_FETCH;
                        end else begin
                            lo_next    = CNT_TWO;
                            hi_next    = last_idx;
                            pos_next   = last_idx;
                            state_next = ST_SEARCH;
                        end
                    end
                    J_DOT: begin
                        res_next   = acc_pos ? POS_OUTSIDE : POS_BOUNDARY;
                        state_next = ST_DONE;
                    end
                    J_SEARCH: begin
                        // The fetch address still holds the midpoint just tested.
                        if (!acc_neg) begin
                            pos_next = fetch_reg;
                            hi_next  = fetch_reg - 1'b1;
                        end else begin
                            lo_next  = fetch_reg + 1'b1;
                        end
                        state_next = ST_SEARCH;
                    end
                    J_FINAL: begin
                        if (acc_pos) begin
                            res_next = POS_INSIDE;
                        end else if (acc_neg) begin
                            res_next = POS_OUTSIDE;
                        end else begin
                            res_next = POS_BOUNDARY;
                        end
                        state_next = ST_DONE;
                    end
                    default: begin
                        res_next   = POS_OUTSIDE;
                        state_next = ST_DONE;
                    end
                endcase
            end

            ST_SEARCH: begin
                if (lo_reg <= hi_reg) begin
                    fetch_next = mid_sum[CNT_W:1];
                    job_next   = J_SEARCH;
                end else begin
                    fetch_next = pos_reg - 1'b1;
                    job_next   = J_PREV;
                end
                state_next = ST_FETCH;
            end

            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    m_position_next = res_reg;
                    m_overflow_next = ovf_reg;
                    state_next      = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------------------------
    // Control registers.
    // ------------------------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            job_reg       <= J_FIRST;
            vcount_reg    <= '0;
            ovf_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
            mac_issue_reg <= 1'b0;
            prod_vld_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            job_reg       <= job_next;
            vcount_reg    <= vcount_next;
            ovf_reg       <= ovf_next;
            m_valid_reg   <= m_valid_next;
            mac_issue_reg <= mac_issue_next;
            prod_vld_reg  <= prod_vld_next;
        end
    end

    // ------------------------------------------------------------------------------------------
    // Payload registers.
    // ------------------------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        px_reg         <= px_next;
        py_reg         <= py_next;
        ox_reg         <= ox_next;
        oy_reg         <= oy_next;
        qx_reg         <= qx_next;
        qy_reg         <= qy_next;
        fetch_reg      <= fetch_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        pos_reg        <= pos_next;
        first_zero_reg <= first_zero_next;
        res_reg        <= res_next;
        m_position_reg <= m_position_next;
        m_overflow_reg <= m_overflow_next;
        a0_reg         <= a0_next;
        b0_reg         <= b0_next;
        a1_reg         <= a1_next;
        b1_reg         <= b1_next;
        sub_reg        <= sub_next;
        term_reg       <= term_next;
        dig_reg        <= dig_next;
        prod_reg       <= prod_next;
        prod_dig_reg   <= prod_dig_next;
        prod_neg_reg   <= prod_neg_next;
        acc_reg        <= acc_next;
    end

    // ------------------------------------------------------------------------------------------
    // Vertex memory: one write port for appends, one registered read port for the sequencer.
    // ------------------------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            vert_mem[vcount_reg[IDX_W-1:0]] <= {in_y, in_x};
        end
        rd_data_reg <= vert_mem[fetch_reg[IDX_W-1:0]];
    end

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_position = m_position_reg;
    assign m_overflow = m_overflow_reg;

endmodule
